### hw/rtl/mac_rx_frame_filter_dedup_defines.svh
// Assertion macros shared by the receive filter RTL.
`ifndef MAC_RX_FRAME_FILTER_DEDUP_DEFINES_SVH
`define MAC_RX_FRAME_FILTER_DEDUP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MRXFD_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define MRXFD_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/mrxfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrxfd_pkg
// Types, codes and header-length helpers of the receive frame filter.
// ----------------------------------------------------------------------------
package mrxfd_pkg;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       frame_start;
      logic       process_flag;
   } mrxfd_req_type;

   typedef struct packed {
      logic        result_kind;
      logic [7:0]  payload_byte;
      logic [2:0]  verdict;
      logic [7:0]  seq_num;
      logic [63:0] src_addr;
      logic [6:0]  pay_len;
      logic        to_broadcast;
   } mrxfd_rsp_type;

   typedef struct packed {
      logic        start;
      logic [63:0] key;
      logic [7:0]  seq;
   } mrxfd_tbl_req_type;

   typedef struct packed {
      logic done;
      logic dup;
   } mrxfd_tbl_rsp_type;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   localparam logic [2:0] VERDICT_MESSAGE   = 3'd0;
   localparam logic [2:0] VERDICT_DATA_REQ  = 3'd1;
   localparam logic [2:0] VERDICT_DUPLICATE = 3'd2;
   localparam logic [2:0] VERDICT_FILTERED  = 3'd3;
   localparam logic [2:0] VERDICT_MALFORMED = 3'd4;

   localparam logic [2:0]  FRAME_TYPE_MAC_CMD = 3'd3;
   localparam logic [7:0]  CMD_DATA_REQUEST   = 8'h04;
   localparam logic [1:0]  ADDR_MODE_NONE     = 2'd0;
   localparam logic [1:0]  ADDR_MODE_SHORT    = 2'd2;
   localparam logic [1:0]  ADDR_MODE_EXT      = 2'd3;
   localparam logic [63:0] SHORT_BROADCAST    = 64'h0000_0000_0000_FFFF;

   localparam int         CSR_ADDR_W      = 4;
   localparam logic [3:0] REG_DEVICE_MAC  = 4'd0;

   function automatic logic [3:0] dpan_len(input logic [15:0] ctrl);
      return (ctrl[11:10] != ADDR_MODE_NONE) ? 4'd2 : 4'd0;
   endfunction

   function automatic logic [3:0] daddr_len(input logic [15:0] ctrl);
      return (ctrl[11:10] == ADDR_MODE_SHORT) ? 4'd2 :
             (ctrl[11:10] == ADDR_MODE_EXT)   ? 4'd8 : 4'd0;
   endfunction

   function automatic logic [3:0] span_len(input logic [15:0] ctrl);
      return ctrl[6] ? 4'd0 : 4'd2;
   endfunction

   function automatic logic [3:0] saddr_len(input logic [15:0] ctrl);
      return (ctrl[15:14] == ADDR_MODE_SHORT) ? 4'd2 :
             (ctrl[15:14] == ADDR_MODE_EXT)   ? 4'd8 : 4'd0;
   endfunction

   function automatic logic [4:0] hdr_len(input logic [15:0] ctrl);
      return 5'd3 + {1'b0, dpan_len(ctrl)} + {1'b0, daddr_len(ctrl)}
           + {1'b0, span_len(ctrl)} + {1'b0, saddr_len(ctrl)};
   endfunction

   function automatic logic is_bcast(input logic [15:0] ctrl, input logic [63:0] dest);
      return (ctrl[11:10] == ADDR_MODE_SHORT) && (dest == SHORT_BROADCAST);
   endfunction

endpackage

### hw/rtl/mrxfd_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrxfd_table
// Duplicate table: walks the entries with one comparator, then updates.
// ----------------------------------------------------------------------------
module mrxfd_table #(
   parameter int TABLE_ENTRIES = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  mrxfd_pkg::mrxfd_tbl_req_type tbl_req,
   output mrxfd_pkg::mrxfd_tbl_rsp_type tbl_rsp
);
   import mrxfd_pkg::*;

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

   localparam logic [1:0] T_IDLE = 2'd0;
   localparam logic [1:0] T_READ = 2'd1;
   localparam logic [1:0] T_CMP  = 2'd2;
   localparam logic [1:0] T_DONE = 2'd3;

   logic [71:0] mem [TABLE_ENTRIES];
   logic [71:0] rd_ff;

   logic [1:0]               st_ff, st_in;
   logic [63:0]              key_ff, key_in;
   logic [7:0]               seq_ff, seq_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [IDX_W-1:0]         ptr_ff, ptr_in;
   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic                     dup_ff, dup_in;

   logic              wr_en;
   logic [IDX_W-1:0]  wr_idx;
   logic [IDX_W-1:0]  rd_idx;

   assign rd_idx = cnt_ff[IDX_W-1:0];

   always_comb begin
      st_in    = st_ff;
      key_in   = key_ff;
      seq_in   = seq_ff;
      cnt_in   = cnt_ff;
      ptr_in   = ptr_ff;
      valid_in = valid_ff;
      dup_in   = dup_ff;
      wr_en    = 1'b0;
      wr_idx   = rd_idx;
      unique case (st_ff)
         T_IDLE: begin
            if (tbl_req.start) begin
               key_in = tbl_req.key;
               seq_in = tbl_req.seq;
               cnt_in = '0;
               st_in  = T_READ;
            end
         end
         T_READ: begin
            if (cnt_ff == CNT_W'(TABLE_ENTRIES)) begin
               // No entry holds this source: take the round-robin slot.
               wr_en            = 1'b1;
               wr_idx           = ptr_ff;
               valid_in[ptr_ff] = 1'b1;
               ptr_in = (ptr_ff == IDX_W'(TABLE_ENTRIES - 1)) ? '0 : ptr_ff + 1'b1;
               dup_in = 1'b0;
               st_in  = T_DONE;
            end else begin
               st_in = T_CMP;
            end
         end
         T_CMP: begin
            if (valid_ff[rd_idx] && (rd_ff[71:8] == key_ff)) begin
               wr_en  = 1'b1;
               dup_in = (rd_ff[7:0] == seq_ff);
               st_in  = T_DONE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
               st_in  = T_READ;
            end
         end
         T_DONE: begin
            st_in = T_IDLE;
         end
         default: st_in = T_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= {key_ff, seq_ff};
      end
      rd_ff <= mem[rd_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= T_IDLE;
         cnt_ff   <= '0;
         ptr_ff   <= '0;
         valid_ff <= '0;
         dup_ff   <= 1'b0;
      end else begin
         st_ff    <= st_in;
         cnt_ff   <= cnt_in;
         ptr_ff   <= ptr_in;
         valid_ff <= valid_in;
         dup_ff   <= dup_in;
      end
      key_ff <= key_in;
      seq_ff <= seq_in;
   end

   assign tbl_rsp.done = (st_ff == T_DONE);
   assign tbl_rsp.dup  = dup_ff;

endmodule

### hw/rtl/mac_rx_frame_filter_dedup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mac_rx_frame_filter_dedup
// Receive filter for 802.15.4 MAC frames with duplicate suppression.
// ----------------------------------------------------------------------------
// The block takes a received frame one byte per beat, starting with the PHY
// length byte (frame_start high). Each byte is parsed combinationally, so
// header and payload bytes are taken back to back while the output is free,
// and a payload byte of an accepted frame leaves as one result beat. The last
// byte of a frame yields one verdict beat. Where the verdict needs the
// duplicate table, a small sequencer walks the table with one shared key
// comparator, one entry at a time, and the next byte is held off until the
// verdict is loaded. The table itself comes out of reset empty and needs no
// clearing pass. The output register lets the next byte in as the previous
// result is taken. device_mac is written through the APB port at address 0.
// ----------------------------------------------------------------------------
module mac_rx_frame_filter_dedup #(
   parameter int TABLE_ENTRIES = 16,
   parameter int PAYLOAD_MAX   = 127
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  mrxfd_pkg::mrxfd_req_type           req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output mrxfd_pkg::mrxfd_rsp_type           rsp_data,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [mrxfd_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [63:0]                        pwdata,
   output logic [63:0]                        prdata,
   output logic                               pready
);
   import mrxfd_pkg::*;
   `include "mac_rx_frame_filter_dedup_defines.svh"

   localparam logic [8:0] PAY_MAX_W = 9'(PAYLOAD_MAX);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_WALK = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   // Configuration register.
   logic [63:0] mac_ff;
   assign pready = 1'b1;
   assign prdata = (paddr == REG_DEVICE_MAC) ? mac_ff : 64'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         mac_ff <= 64'd0;
      end else if (psel && penable && pwrite && pready && (paddr == REG_DEVICE_MAC)) begin
         mac_ff <= pwdata;
      end
   end

   // Frame parse state.
   logic [1:0]  state_ff, state_in;
   logic [7:0]  pos_ff, pos_in;
   logic [7:0]  len_ff, len_in;
   logic [15:0] ctrl_ff, ctrl_in;
   logic [7:0]  seq_ff, seq_in;
   logic [63:0] dest_ff, dest_in;
   logic [63:0] src_ff, src_in;
   logic        in_frame_ff, in_frame_in;
   logic        proc_ff, proc_in;
   logic        acc_ff, acc_in;
   logic        dreq_ff, dreq_in;
   logic        dup_ff, dup_in;

   logic          rsp_valid_ff, rsp_valid_in;
   mrxfd_rsp_type rsp_data_ff;
   mrxfd_rsp_type out_nx;
   logic          out_load;
   logic          slot_free;
   logic          req_fire;

   mrxfd_tbl_req_type tbl_req;
   mrxfd_tbl_rsp_type tbl_rsp;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !slot_free;
   assign req_fire  = req_valid && !req_stall;

   // Header and payload bookkeeping for the byte in hand.
   logic [7:0] p;
   logic [7:0] h;
   logic [7:0] idx;
   logic [7:0] pidx;
   logic [7:0] b1, b2, b3, b4;
   logic [7:0] paycnt;
   logic       wf;
   logic       pay_out;
   logic [7:0] b;

   always_comb begin
      state_in    = state_ff;
      pos_in      = pos_ff;
      len_in      = len_ff;
      ctrl_in     = ctrl_ff;
      seq_in      = seq_ff;
      dest_in     = dest_ff;
      src_in      = src_ff;
      in_frame_in = in_frame_ff;
      proc_in     = proc_ff;
      acc_in      = acc_ff;
      dreq_in     = dreq_ff;
      dup_in      = dup_ff;
      out_load    = 1'b0;
      out_nx      = '0;
      tbl_req     = '0;
      pay_out     = 1'b0;
      b           = req_data.rx_byte;
      p           = pos_ff + 8'd1;
      idx         = p - 8'd4;
      h           = 8'd0;
      b1          = 8'd0;
      b2          = 8'd0;
      b3          = 8'd0;
      b4          = 8'd0;
      pidx        = 8'd0;
      paycnt      = 8'd0;
      wf          = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_data.frame_start) begin
               len_in      = b;
               pos_in      = 8'd0;
               ctrl_in     = 16'd0;
               seq_in      = 8'd0;
               dest_in     = 64'd0;
               src_in      = 64'd0;
               in_frame_in = (b != 8'd0);
               proc_in     = req_data.process_flag;
               acc_in      = 1'b0;
               dreq_in     = 1'b0;
               if (b == 8'd0) begin
                  // An empty frame is judged on its length byte alone.
                  out_load       = 1'b1;
                  out_nx.result_kind = KIND_VERDICT;
                  out_nx.verdict = VERDICT_MALFORMED;
               end
            end else if (req_fire && in_frame_ff) begin
               pos_in = p;
               if (p == 8'd1) begin
                  ctrl_in = {8'd0, b};
               end else if (p == 8'd2) begin
                  ctrl_in = {b, ctrl_ff[7:0]};
               end else if (p == 8'd3) begin
                  seq_in = b;
               end
               // From here on the control word is complete.
               h      = {3'd0, hdr_len(ctrl_in)};
               wf     = ({1'b0, len_ff} >= ({1'b0, h} + 9'd2)) &&
                        (({1'b0, len_ff} - {1'b0, h} - 9'd2) <= PAY_MAX_W);
               paycnt = len_ff - h - 8'd2;
               b1     = {4'd0, dpan_len(ctrl_in)};
               b2     = b1 + {4'd0, daddr_len(ctrl_in)};
               b3     = b2 + {4'd0, span_len(ctrl_in)};
               b4     = b3 + {4'd0, saddr_len(ctrl_in)};
               pidx   = p - (h + 8'd1);
               if (p >= 8'd4) begin
                  if (idx < b1) begin
                     // Destination PAN is not used.
                  end else if (idx < b2) begin
                     dest_in[{idx[2:0] - b1[2:0], 3'b000} +: 8] = b;
                  end else if (idx < b3) begin
                     // Source PAN is not used.
                  end else if (idx < b4) begin
                     src_in = {src_ff[55:0], b};
                  end else if (wf && acc_ff && (pidx < paycnt)) begin
                     pay_out = 1'b1;
                     if ((pidx == 8'd0) && (b == CMD_DATA_REQUEST)) begin
                        dreq_in = 1'b1;
                     end
                     out_load            = 1'b1;
                     out_nx.result_kind  = KIND_PAYLOAD;
                     out_nx.payload_byte = b;
                     out_nx.seq_num      = seq_in;
                     out_nx.src_addr     = src_in;
                     out_nx.to_broadcast = is_bcast(ctrl_in, dest_in);
                  end
               end
               if (!pay_out && (p >= 8'd3) && (p == h)) begin
                  if (proc_ff && (ctrl_in[15:14] == ADDR_MODE_EXT) &&
                      (((ctrl_in[11:10] == ADDR_MODE_EXT) && (dest_in == mac_ff)) ||
                       is_bcast(ctrl_in, dest_in))) begin
                     acc_in = 1'b1;
                  end
               end
               if (!pay_out && (p == len_ff)) begin
                  in_frame_in         = 1'b0;
                  out_nx.result_kind  = KIND_VERDICT;
                  out_nx.seq_num      = seq_in;
                  out_nx.src_addr     = src_in;
                  out_nx.to_broadcast = is_bcast(ctrl_in, dest_in);
                  priority if (!wf) begin
                     out_load       = 1'b1;
                     out_nx.verdict = VERDICT_MALFORMED;
                  end else if (!acc_in) begin
                     out_load       = 1'b1;
                     out_nx.verdict = VERDICT_FILTERED;
                  end else if ((ctrl_in[2:0] == FRAME_TYPE_MAC_CMD) &&
                               (paycnt != 8'd0) && dreq_in) begin
                     out_load       = 1'b1;
                     out_nx.verdict = VERDICT_DATA_REQ;
                     out_nx.pay_len = paycnt[6:0];
                  end else begin
                     // Message or duplicate: the table decides.
                     tbl_req.start = 1'b1;
                     tbl_req.key   = src_in;
                     tbl_req.seq   = seq_in;
                     state_in      = ST_WALK;
                  end
               end
            end
         end
         ST_WALK: begin
            if (tbl_rsp.done) begin
               dup_in   = tbl_rsp.dup;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               h                   = {3'd0, hdr_len(ctrl_ff)};
               paycnt              = len_ff - h - 8'd2;
               out_load            = 1'b1;
               out_nx.result_kind  = KIND_VERDICT;
               out_nx.verdict      = dup_ff ? VERDICT_DUPLICATE : VERDICT_MESSAGE;
               out_nx.seq_num      = seq_ff;
               out_nx.src_addr     = src_ff;
               out_nx.pay_len      = paycnt[6:0];
               out_nx.to_broadcast = is_bcast(ctrl_ff, dest_ff);
               state_in            = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = out_load ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= 8'd0;
         len_ff       <= 8'd0;
         ctrl_ff      <= 16'd0;
         seq_ff       <= 8'd0;
         dest_ff      <= 64'd0;
         src_ff       <= 64'd0;
         in_frame_ff  <= 1'b0;
         proc_ff      <= 1'b0;
         acc_ff       <= 1'b0;
         dreq_ff      <= 1'b0;
         dup_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         len_ff       <= len_in;
         ctrl_ff      <= ctrl_in;
         seq_ff       <= seq_in;
         dest_ff      <= dest_in;
         src_ff       <= src_in;
         in_frame_ff  <= in_frame_in;
         proc_ff      <= proc_in;
         acc_ff       <= acc_in;
         dreq_ff      <= dreq_in;
         dup_ff       <= dup_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= out_nx;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   mrxfd_table #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .tbl_req (tbl_req),
      .tbl_rsp (tbl_rsp)
   );

   // A payload beat being loaded into the output register.
   logic pay_beat;
   assign pay_beat = out_load && (out_nx.result_kind == KIND_PAYLOAD);

   // The table only answers a lookup that the parser is waiting for.
   `MRXFD_ASSERT_IMP(a_done_in_walk, clock, reset, tbl_rsp.done, state_ff == ST_WALK, "late answer")
   // Starting a lookup always parks the parser in the walk state.
   `MRXFD_ASSERT_NXT(a_start_walks, clock, reset, tbl_req.start, state_ff == ST_WALK, "no walk")
   // Payload beats are only produced for frames that passed the filter.
   `MRXFD_ASSERT_IMP(a_pay_accepted, clock, reset, pay_beat, acc_ff, "payload not accepted")

endmodule

### tb/tb_mac_rx_frame_filter_dedup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mac_rx_frame_filter_dedup
// Self-checking bench for the MAC receive frame filter with duplicate table.
// ----------------------------------------------------------------------------
// Frames are built as byte streams (length byte first) and queued for a
// bursty driver. Every accepted byte is run through a bit-accurate predictor
// of the parser, the address filter and the bounded duplicate table; the
// payload and verdict beats that come out are checked in order against it.
// The device address is changed between phases, with the block idle, and
// the receiver stalls lightly, heavily, not at all, and once for a long
// stretch so that the block backs up into its input.
// ----------------------------------------------------------------------------
module tb_mac_rx_frame_filter_dedup;
   import mrxfd_pkg::*;

   localparam int TBL_N   = 16;
   localparam int PAY_MAX = 127;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   mrxfd_req_type req_data = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   mrxfd_rsp_type rsp_data;
   logic          psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [63:0]   pwdata = '0;
   logic [63:0]   prdata;
   logic          pready;

   mac_rx_frame_filter_dedup uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Bytes waiting to be driven, and the beats the filter is expected to send.
   mrxfd_req_type pending_bytes[$];
   mrxfd_rsp_type expected_beats[$];
   int            errors = 0;
   int            verdict_count[5];
   int            payload_beats = 0;

   // ---------------------------------------------------------------------
   // Predictor state: a private copy of the parser registers and the table.
   // ---------------------------------------------------------------------
   logic [63:0] own_mac = '0;
   logic [63:0] seen_key[TBL_N];
   logic [7:0]  seen_seq[TBL_N];
   bit          seen_vld[TBL_N];
   int          repl_ptr = 0;
   int          byte_pos = 0;
   int          frame_len = 0;
   logic [15:0] fctl = '0;
   logic [7:0]  fseq = '0;
   logic [63:0] fdst = '0;
   logic [63:0] fsrc = '0;
   bit          in_frame = 0, want_proc = 0, accepted = 0, cmd_first = 0;

   function automatic int dst_pan_bytes();
      return (fctl[11:10] != ADDR_MODE_NONE) ? 2 : 0;
   endfunction

   function automatic int dst_addr_bytes();
      return (fctl[11:10] == ADDR_MODE_SHORT) ? 2 : (fctl[11:10] == ADDR_MODE_EXT) ? 8 : 0;
   endfunction

   function automatic int src_pan_bytes();
      return fctl[6] ? 0 : 2;
   endfunction

   function automatic int src_addr_bytes();
      return (fctl[15:14] == ADDR_MODE_SHORT) ? 2 : (fctl[15:14] == ADDR_MODE_EXT) ? 8 : 0;
   endfunction

   function automatic int header_bytes();
      return 3 + dst_pan_bytes() + dst_addr_bytes() + src_pan_bytes() + src_addr_bytes();
   endfunction

   function automatic bit dst_is_broadcast();
      return fctl[11:10] == ADDR_MODE_SHORT && fdst == SHORT_BROADCAST;
   endfunction

   function automatic bit length_ok();
      int h;
      h = header_bytes();
      return frame_len >= h + 2 && frame_len - h - 2 <= PAY_MAX;
   endfunction

   function automatic int payload_count();
      return frame_len - header_bytes() - 2;
   endfunction

   function automatic mrxfd_rsp_type make_beat(logic kind, logic [7:0] pb, logic [2:0] vd,
                                                int plen);
      mrxfd_rsp_type r;
      r.result_kind  = kind;
      r.payload_byte = pb;
      r.verdict      = vd;
      r.seq_num      = fseq;
      r.src_addr     = fsrc;
      r.pay_len      = plen[6:0];
      r.to_broadcast = dst_is_broadcast();
      return r;
   endfunction

   // Gives the class; all but data requests look up and update the dedup table.
   function automatic logic [2:0] classify_frame();
      int hit;
      logic [2:0] vd;
      hit = -1;
      if (fctl[2:0] == FRAME_TYPE_MAC_CMD && payload_count() > 0 && cmd_first)
         return VERDICT_DATA_REQ;
      for (int i = 0; i < TBL_N; i++) begin
         if (hit < 0 && seen_vld[i] && seen_key[i] == fsrc) hit = i;
      end
      vd = (hit >= 0 && seen_seq[hit] == fseq) ? VERDICT_DUPLICATE : VERDICT_MESSAGE;
      if (hit < 0) begin
         hit = repl_ptr;
         repl_ptr = (repl_ptr + 1) % TBL_N;
         seen_key[hit] = fsrc;
         seen_vld[hit] = 1;
      end
      seen_seq[hit] = fseq;
      return vd;
   endfunction

   function automatic mrxfd_rsp_type close_frame();
      in_frame = 0;
      if (!length_ok()) return make_beat(KIND_VERDICT, 8'h00, VERDICT_MALFORMED, 0);
      if (!accepted) return make_beat(KIND_VERDICT, 8'h00, VERDICT_FILTERED, 0);
      return make_beat(KIND_VERDICT, 8'h00, classify_frame(), payload_count());
   endfunction

   // Advances the parser by one byte; returns 1 when the byte yields a beat.
   function automatic bit filter_byte(input mrxfd_req_type it, output mrxfd_rsp_type r);
      logic [7:0] b;
      int idx, h, dpan, dend, spend;
      b = it.rx_byte;
      r = '0;
      if (it.frame_start) begin
         frame_len = int'(b);
         byte_pos = 0;
         fctl = '0; fseq = '0; fdst = '0; fsrc = '0;
         in_frame = 1; want_proc = it.process_flag; accepted = 0; cmd_first = 0;
         if (frame_len == 0) begin
            r = close_frame();
            return 1;
         end
         return 0;
      end
      if (!in_frame) return 0;
      byte_pos = (byte_pos + 1) & 255;
      if (byte_pos == 1) fctl = {8'h00, b};
      else if (byte_pos == 2) fctl[15:8] = b;
      else if (byte_pos == 3) fseq = b;
      else begin
         h = header_bytes();
         idx = byte_pos - 4;
         dpan = dst_pan_bytes();
         dend = dpan + dst_addr_bytes();
         spend = dend + src_pan_bytes();
         if (idx < dpan) begin
            // destination PAN is not used
         end else if (idx < dend) begin
            fdst[8*(idx - dpan) +: 8] = b;
         end else if (idx < spend) begin
            // source PAN is not used
         end else if (idx < spend + src_addr_bytes()) begin
            fsrc = {fsrc[55:0], b};
         end else if (length_ok() && accepted) begin
            idx = byte_pos - (h + 1);
            if (idx < payload_count()) begin
               if (idx == 0 && b == CMD_DATA_REQUEST) cmd_first = 1;
               r = make_beat(KIND_PAYLOAD, b, VERDICT_MESSAGE, 0);
               return 1;
            end
         end
      end
      // The filter decision is taken on the last header byte.
      if (byte_pos >= 3 && byte_pos == header_bytes()) begin
         if (want_proc && fctl[15:14] == ADDR_MODE_EXT &&
             ((fctl[11:10] == ADDR_MODE_EXT && fdst == own_mac) || dst_is_broadcast()))
            accepted = 1;
      end
      if (byte_pos == frame_len) begin
         r = close_frame();
         return 1;
      end
      return 0;
   endfunction

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         errors++;
      end
   endtask

   // ---------------------------------------------------------------------
   // Monitor: results are checked before the byte taken on the same edge is
   // predicted, since that byte's beats can only appear on later edges.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      mrxfd_rsp_type want, beat;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_beats.size() == 0) begin
               $display("%0t: unexpected beat, expected none, got %0h", $time, rsp_data);
               errors++;
            end else begin
               want = expected_beats.pop_front();
               check_field("result_kind", 64'(want.result_kind),
                           64'(rsp_data.result_kind));
               check_field("payload_byte", 64'(want.payload_byte),
                           64'(rsp_data.payload_byte));
               check_field("verdict", 64'(want.verdict), 64'(rsp_data.verdict));
               check_field("seq_num", 64'(want.seq_num), 64'(rsp_data.seq_num));
               check_field("src_addr", want.src_addr, rsp_data.src_addr);
               check_field("pay_len", 64'(want.pay_len), 64'(rsp_data.pay_len));
               check_field("to_broadcast", 64'(want.to_broadcast),
                           64'(rsp_data.to_broadcast));
               if (want.result_kind == KIND_VERDICT) verdict_count[want.verdict]++;
               else payload_beats++;
            end
         end
         if (req_valid && !req_stall) begin
            if (filter_byte(req_data, beat)) expected_beats.push_back(beat);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Driver: bursts of random length separated by random gaps. A new byte is
   // only presented once the current one has been taken.
   // ---------------------------------------------------------------------
   int burst_left = 1;
   int gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_bytes.size() > 0) begin
            req_data <= pending_bytes.pop_front();
            req_valid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 40);
               gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Receiver: stalls to a per-phase pattern, or holds off for a long stretch
   // once when asked, so that the output register and then the input back up.
   // ---------------------------------------------------------------------
   int stall_mode = 0;
   bit hold_request = 0;
   int hold_left = 0;

   always @(posedge clock) begin
      if (hold_request) begin
         hold_request = 0;
         hold_left = 400;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            default: rsp_stall <= ($urandom_range(0, 9) < 7);
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus.
   // ---------------------------------------------------------------------
   logic [63:0] src_pool[20];

   task automatic csr_write_mac(logic [63:0] value);
      @(posedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= REG_DEVICE_MAC; pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      own_mac = value;
   endtask

   // Builds one frame. len_adj skews the length byte away from the true size,
   // and a non-zero cut stops the stream after that many bytes of the body.
   task automatic push_frame(bit proc, logic [2:0] ftype, logic [1:0] dmode,
                             logic [1:0] smode, bit panc, logic [7:0] seq,
                             logic [63:0] dst, logic [63:0] src, int npay,
                             int first, int len_adj, int cut);
      logic [7:0] body[$];
      logic [15:0] ctl;
      mrxfd_req_type it;
      int dlen, slen, flen;
      ctl = 16'($urandom);
      ctl[2:0] = ftype; ctl[6] = panc; ctl[11:10] = dmode; ctl[15:14] = smode;
      dlen = (dmode == ADDR_MODE_SHORT) ? 2 : (dmode == ADDR_MODE_EXT) ? 8 : 0;
      slen = (smode == ADDR_MODE_SHORT) ? 2 : (smode == ADDR_MODE_EXT) ? 8 : 0;
      body.push_back(ctl[7:0]);
      body.push_back(ctl[15:8]);
      body.push_back(seq);
      if (dmode != ADDR_MODE_NONE) repeat (2) body.push_back(8'($urandom));
      // Destination goes out least significant byte first, source the other way.
      for (int i = 0; i < dlen; i++) body.push_back(dst[8*i +: 8]);
      if (!panc) repeat (2) body.push_back(8'($urandom));
      for (int i = slen - 1; i >= 0; i--) body.push_back(src[8*i +: 8]);
      for (int i = 0; i < npay; i++)
         body.push_back((i == 0 && first >= 0) ? first[7:0] : 8'($urandom));
      repeat (2) body.push_back(8'($urandom));
      flen = body.size() + len_adj;
      if (flen < 0) flen = 0;
      if (flen > 255) flen = 255;
      it.rx_byte = flen[7:0]; it.frame_start = 1'b1; it.process_flag = proc;
      pending_bytes.push_back(it);
      if (cut > 0 && cut < body.size()) body = body[0:cut-1];
      foreach (body[i]) begin
         it.rx_byte = body[i]; it.frame_start = 1'b0; it.process_flag = 1'($urandom);
         pending_bytes.push_back(it);
      end
   endtask

   task automatic push_loose_byte(logic [7:0] b);
      mrxfd_req_type it;
      it.rx_byte = b; it.frame_start = 1'b0; it.process_flag = 1'($urandom);
      pending_bytes.push_back(it);
   endtask

   // Random traffic, mostly well-formed frames aimed at this device or at
   // broadcast, drawn from a pool of sources larger than the table.
   task automatic push_random_traffic(int n_bytes);
      int goal, pick, npay, first;
      logic [1:0] dm;
      logic [63:0] dst;
      goal = pending_bytes.size() + n_bytes;
      while (pending_bytes.size() < goal) begin
         pick = $urandom_range(0, 99);
         if (pick < 4) begin
            push_loose_byte(8'($urandom));
         end else begin
            pick = $urandom_range(0, 9);
            dm = (pick < 4) ? ADDR_MODE_SHORT : (pick < 8) ? ADDR_MODE_EXT : 2'($urandom);
            dst = (pick < 4) ? SHORT_BROADCAST : (pick < 8) ? own_mac : {$urandom, $urandom};
            if (dm == ADDR_MODE_SHORT && pick >= 8) dst = 64'($urandom_range(0, 16'hFFFF));
            npay = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 128) : $urandom_range(0, 8);
            first = ($urandom_range(0, 1) == 0) ? CMD_DATA_REQUEST : -1;
            push_frame($urandom_range(0, 9) != 0,
                       ($urandom_range(0, 2) == 0) ? FRAME_TYPE_MAC_CMD : 3'($urandom),
                       dm, ($urandom_range(0, 6) != 0) ? ADDR_MODE_EXT : 2'($urandom),
                       1'($urandom), 8'($urandom_range(0, 3)), dst,
                       src_pool[$urandom_range(0, 19)], npay, first,
                       ($urandom_range(0, 14) == 0) ? int'($urandom_range(0, 12)) - 8 : 0,
                       ($urandom_range(0, 19) == 0) ? $urandom_range(1, 12) : 0);
         end
      end
   endtask

   // Lets the queue drain and every beat arrive, so that the block is idle
   // before the next CSR write.
   task automatic drain();
      @(negedge clock);
      while (pending_bytes.size() > 0 || req_valid || expected_beats.size() > 0)
         @(negedge clock);
      repeat (100) @(posedge clock);
   endtask

   initial begin
      logic [63:0] mac;
      logic [63:0] s0;
      mrxfd_req_type it;
      foreach (src_pool[i]) src_pool[i] = {$urandom, $urandom};
      s0 = src_pool[0];
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed frames.
      mac = {$urandom, $urandom};
      csr_write_mac(mac);
      stall_mode = 1;
      push_frame(1, 3'd1, ADDR_MODE_EXT, ADDR_MODE_EXT, 1, 8'd5, mac, s0, 3, -1, 0, 0);
      push_frame(1, 3'd1, ADDR_MODE_EXT, ADDR_MODE_EXT, 1, 8'd5, mac, s0, 3, -1, 0, 0);
      push_frame(1, 3'd1, ADDR_MODE_SHORT, ADDR_MODE_EXT, 0, 8'hFF, SHORT_BROADCAST,
                 64'hFFFF_FFFF_FFFF_FFFF, 2, 8'hFF, 0, 0);
      push_frame(1, FRAME_TYPE_MAC_CMD, ADDR_MODE_EXT, ADDR_MODE_EXT, 1, 8'd6, mac, s0, 1,
                 CMD_DATA_REQUEST, 0, 0);
      push_frame(1, FRAME_TYPE_MAC_CMD, ADDR_MODE_EXT, ADDR_MODE_EXT, 1, 8'd6, mac, s0, 0,
                 -1, 0, 0);
      push_frame(0, 3'd1, ADDR_MODE_EXT, ADDR_MODE_EXT, 1, 8'd7, mac, s0, 2, -1, 0, 0);
      push_frame(1, 3'd1, ADDR_MODE_EXT, ADDR_MODE_SHORT, 1, 8'd8, mac, s0, 2, -1, 0, 0);
      push_frame(1, 3'd1, ADDR_MODE_EXT, ADDR_MODE_EXT, 1, 8'd9, ~mac, s0, 2, -1, 0, 0);
      push_frame(1, 3'd1, 2'd1, ADDR_MODE_EXT, 1, 8'd10, mac, s0, 2, -1, 0, 0);
      push_frame(1, 3'd1, ADDR_MODE_NONE, ADDR_MODE_EXT, 1, 8'd11, mac, s0, 2, -1, 0, 0);
      it.rx_byte = 8'h00; it.frame_start = 1'b1; it.process_flag = 1'b1;
      pending_bytes.push_back(it);
      push_frame(1, 3'd1, ADDR_MODE_EXT, ADDR_MODE_EXT, 1, 8'd12, mac, s0, 0, -1, -3, 0);
      push_frame(1, 3'd1, ADDR_MODE_EXT, ADDR_MODE_EXT, 1, 8'd13, mac, s0, 128, -1, 0, 0);
      push_frame(1, 3'd1, ADDR_MODE_SHORT, ADDR_MODE_EXT, 1, 8'd14, SHORT_BROADCAST, s0,
                 PAY_MAX, 8'h00, 0, 0);
      push_frame(1, 3'd1, ADDR_MODE_EXT, ADDR_MODE_EXT, 1, 8'd15, mac, s0, 4, -1, 0, 6);
      push_frame(1, 3'd1, ADDR_MODE_EXT, ADDR_MODE_EXT, 1, 8'd16, mac, src_pool[1], 1,
                 -1, 0, 0);
      push_loose_byte(8'h00);
      push_loose_byte(8'hFF);
      drain();

      // Random phases, each with a new device address and receiver pattern.
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: mac = 64'h0;
            1: mac = 64'hFFFF_FFFF_FFFF_FFFF;
            default: mac = {$urandom, $urandom};
         endcase
         csr_write_mac(mac);
         stall_mode = ph % 3;
         push_random_traffic(135);
         if (ph == 2) begin
            // Long hold-off while the sender keeps offering bytes.
            repeat (20) @(posedge clock);
            hold_request = 1;
         end
         drain();
      end

      $display("Frames: %0d message, %0d data request, %0d duplicate, %0d filtered,",
               verdict_count[0], verdict_count[1], verdict_count[2], verdict_count[3]);
      $display("%0d malformed; %0d payload beats checked over five address settings.",
               verdict_count[4], payload_beats);
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("Timed out waiting for the filter to drain.");
      $display("Some tests failed");
      $finish;
   end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/mrxfd_pkg.sv
hw/rtl/mrxfd_table.sv
hw/rtl/mac_rx_frame_filter_dedup.sv
tb/tb_mac_rx_frame_filter_dedup.sv
